// ===== hw/rtl/srva_pkg.sv =====
// Shared types and constants for the section RVA to file offset translator.
// Used by the section table, the remainder unit and the top level.
package srva_pkg;

	localparam int MAX_SECTIONS_DEF = 16;

	localparam logic [31:0] RAW_ROUND      = 32'h0000_0200;
	localparam logic [31:0] RAW_MASK       = ~(RAW_ROUND - 32'd1);
	localparam logic [31:0] SECT_MIN_ALIGN = 32'h0000_1000;

	localparam logic [31:0] FILE_ALIGN_RST = 32'h0000_0200;
	localparam logic [31:0] SECT_ALIGN_RST = 32'h0000_1000;
	localparam logic [4:0]  SECT_COUNT_RST = 5'd0;

	// configuration register indexes
	localparam logic [1:0] CFG_FILE_ALIGN = 2'd0;
	localparam logic [1:0] CFG_SECT_ALIGN = 2'd1;
	localparam logic [1:0] CFG_SECT_COUNT = 2'd2;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_XLATE = 1'b1;

	typedef struct packed {
		logic [31:0] vaddr;
		logic [31:0] vsize;
		logic [31:0] raw_ptr;
	} sect_ent_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_DIV,
		S_DONE
	} state_t;

endpackage

// ===== hw/rtl/srva_if.sv =====
// Handshake channels of the translator: request words in, result words out.
// Standalone; no package needed.
interface srva_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  slot;
	logic [31:0] sect_vaddr;
	logic [31:0] sect_vsize;
	logic [31:0] sect_raw_ptr;
	logic [31:0] rel_addr;

	modport source (output valid, req_type, slot, sect_vaddr, sect_vsize, sect_raw_ptr,
		rel_addr, input ready);
	modport sink (input valid, req_type, slot, sect_vaddr, sect_vsize, sect_raw_ptr,
		rel_addr, output ready);
endinterface

interface srva_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] file_offset;
	logic [3:0]  hit_slot;
	logic        not_found;

	modport source (output valid, file_offset, hit_slot, not_found, input ready);
	modport sink (input valid, file_offset, hit_slot, not_found, output ready);
endinterface

// ===== hw/rtl/srva_mem.sv =====
// Section table storage: one write port, one registered read port.
// Depends on srva_pkg for the entry type.
module srva_mem
	import srva_pkg::*;
#(
	parameter int DEPTH = MAX_SECTIONS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  sect_ent_t     wr_data,
	input  logic [AW-1:0] rd_addr,
	output sect_ent_t     rd_data
);

	sect_ent_t mem_q [DEPTH];
	sect_ent_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== hw/rtl/srva_div.sv =====
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on srva_pkg for the request and response structs.
module srva_div
	import srva_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] dq_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	logic [32:0] part;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		part  = {rem_q, dq_q[31]};
		trial = (part >= {1'b0, dvs_q}) ? (part - {1'b0, dvs_q}) : part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= trial[31:0];
			dq_q  <= {dq_q[30:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== hw/rtl/section_rva_to_file_offset.sv =====
// Top level of the section RVA to file offset translator: sequencer, config
// registers and result register. Depends on srva_pkg, srva_if, srva_mem, srva_div.
//
//   channel | dir | handshake         | word
//   req     | in  | valid/ready       | load entry or address to translate
//   rsp     | out | valid/ready       | file_offset, hit_slot, not_found
//   cfg     | in  | cfg_we, no ready  | cfg_idx selects register, cfg_wdata
//
// A load word is written to the table at acceptance.
// A translate word scans the slots in order (one table read and one
// range compare per slot), then runs the serial remainder unit on a hit
// with nonzero alignment; a result stall can hold the finished result.
// Ready is high only while idle. A finished result waits in a holding register
// until the output register is free. Reset clears control state; table is not cleared.
module section_rva_to_file_offset
	import srva_pkg::*;
#(
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	srva_req_if.sink    req,
	srva_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CW = $clog2(MAX_SECTIONS + 1);

	state_t      state_q, state_d;
	logic [31:0] cfg_falign_q;
	logic [31:0] cfg_salign_q;
	logic [4:0]  cfg_count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] lim_q;
	logic [CW-1:0] lim_d;
	logic [31:0] rva_q;
	logic [31:0] al_q;
	logic [31:0] al_d;
	logic [31:0] res_off_q;
	logic [3:0]  res_slot_q;
	logic        res_nf_q;
	logic        out_vld_q;
	logic [31:0] out_off_q;
	logic [3:0]  out_slot_q;
	logic        out_nf_q;

	logic        acc;
	logic        acc_xlate;
	logic        ld_en;
	sect_ent_t   ent;
	sect_ent_t   wr_ent;
	logic [31:0] raw_r;
	logic [31:0] top_sum;
	logic        in_range;
	logic        last;
	logic        out_load;
	logic        rdy;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	assign acc       = req.valid && rdy;
	assign acc_xlate = acc && (req.req_type == REQ_XLATE);
	assign ld_en     = acc && (req.req_type == REQ_LOAD) && (int'(req.slot) < MAX_SECTIONS);

	assign wr_ent.vaddr   = req.sect_vaddr;
	assign wr_ent.vsize   = req.sect_vsize;
	assign wr_ent.raw_ptr = req.sect_raw_ptr;

	srva_mem #(
		.DEPTH (MAX_SECTIONS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (ld_en),
		.wr_addr (AW'(req.slot)),
		.wr_data (wr_ent),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (ent)
	);

	srva_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// clamp the search count to the table depth
	assign lim_d = (int'(cfg_count_q) > MAX_SECTIONS) ? CW'(MAX_SECTIONS) : CW'(cfg_count_q);
	assign al_d  = (cfg_salign_q < SECT_MIN_ALIGN) ? cfg_falign_q : cfg_salign_q;

	assign raw_r    = (cfg_falign_q < RAW_ROUND) ? ent.raw_ptr : (ent.raw_ptr & RAW_MASK);
	assign top_sum  = ent.vaddr + ent.vsize;
	assign in_range = (rva_q >= ent.vaddr) && (rva_q <= top_sum);
	assign last     = (idx_q + CW'(1)) == lim_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_xlate) begin
					state_d = (lim_d == '0) ? S_DONE : S_RD;
				end
			end
			S_RD: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (in_range) begin
					state_d = (al_q == '0) ? S_DONE : S_DIV;
				end else if (last) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RD;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rdy              = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = ent.vaddr;
		div_req.divisor  = al_q;
		case (state_q)
			S_IDLE: rdy = 1'b1;
			S_CMP:  div_req.start = in_range && (al_q != '0);
			S_DONE: out_load = !out_vld_q || rsp.ready;
			default: begin
				rdy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cfg_falign_q <= FILE_ALIGN_RST;
			cfg_salign_q <= SECT_ALIGN_RST;
			cfg_count_q  <= SECT_COUNT_RST;
			idx_q        <= '0;
			lim_q        <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_FILE_ALIGN: cfg_falign_q <= cfg_wdata;
					CFG_SECT_ALIGN: cfg_salign_q <= cfg_wdata;
					CFG_SECT_COUNT: cfg_count_q  <= cfg_wdata[4:0];
					default: begin
						cfg_count_q <= cfg_count_q;
					end
				endcase
			end
			if (acc_xlate) begin
				idx_q <= '0;
				lim_q <= lim_d;
			end else if (state_q == S_CMP && !in_range && !last) begin
				idx_q <= idx_q + CW'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_xlate) begin
			rva_q      <= req.rel_addr;
			al_q       <= al_d;
			// preset a miss
			res_off_q  <= '0;
			res_slot_q <= '0;
			res_nf_q   <= 1'b1;
		end else if (state_q == S_CMP && in_range) begin
			res_off_q  <= rva_q + raw_r - ent.vaddr;
			res_slot_q <= 4'(idx_q);
			res_nf_q   <= 1'b0;
		end else if (state_q == S_DIV && div_rsp.done) begin
			// vaddr rounded down is vaddr minus remainder: add it back
			res_off_q <= res_off_q + div_rsp.rem;
		end
		if (out_load) begin
			out_off_q  <= res_off_q;
			out_slot_q <= res_slot_q;
			out_nf_q   <= res_nf_q;
		end
	end

	assign req.ready       = rdy;
	assign rsp.valid       = out_vld_q;
	assign rsp.file_offset = out_off_q;
	assign rsp.hit_slot    = out_slot_q;
	assign rsp.not_found   = out_nf_q;

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("remainder unit finished outside the divide state");

	a_idx_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_CMP) |-> (idx_q < lim_q))
		else $error("scan index ran past the search limit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.not_found) |-> (rsp.file_offset == '0 && rsp.hit_slot == '0))
		else $error("miss result carries nonzero offset or slot");

	a_xlate_starts: assert property (@(posedge clk) disable iff (!arst_n)
		acc_xlate |=> (state_q == S_RD || state_q == S_DONE))
		else $error("translate word did not start a scan");
`endif

endmodule
